// ----- rtl/tvfc_pkg.sv -----
// ----------------------------------------------------------------------------
// tvfc_pkg
// Shared widths, constants and types for the time-varying FIR convolver.
// ----------------------------------------------------------------------------
package tvfc_pkg;

	localparam int MAX_TAPS = 1024;
	localparam int PTR_W    = $clog2(MAX_TAPS);
	localparam int TAP_W    = 11;
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int ACC_W    = PROD_W + PTR_W;
	localparam int FRAC_W   = SAMPLE_W - 1;
	localparam int QUOT_W   = ACC_W - FRAC_W;

	typedef logic [PTR_W-1:0]           ptr_t;
	typedef logic [TAP_W-1:0]           taps_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_MAC   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_ROUND = 5'b10000
	} state_t;

endpackage

// ----- rtl/time_varying_fir_convolver.sv -----
// ----------------------------------------------------------------------------
// time_varying_fir_convolver
// Direct-form time-varying FIR with shared-pointer input and response rings.
// ----------------------------------------------------------------------------
//  channel  | signals                                        | flow
//  ---------+------------------------------------------------+-----------
//  input    | in_valid, in_stall, in_sample, ir_sample,      | into block
//           | write_input, write_response                    |
//  output   | out_valid, out_stall, out_sample               | out of block
//  config   | cfg_wr_en, cfg_wr_data (tap_count)             | into block
//
//  For each transfer in, one shared multiplier-accumulator
//  walks both ring memories one tap per cycle, then the sum is rounded.
//  After reset both rings are zeroed, and in_stall stays high meanwhile.
//  The finished sample waits in the output register, so the next input
//  transfer may be taken while out_stall holds the previous result.
// ----------------------------------------------------------------------------
module time_varying_fir_convolver (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [tvfc_pkg::SAMPLE_W-1:0] in_sample,
	input  logic signed [tvfc_pkg::SAMPLE_W-1:0] ir_sample,
	input  logic                          write_input,
	input  logic                          write_response,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [tvfc_pkg::SAMPLE_W-1:0] out_sample,
	input  logic                          cfg_wr_en,
	input  logic [tvfc_pkg::TAP_W-1:0]    cfg_wr_data
);

	tvfc_pkg::sample_t in_ring_mem [tvfc_pkg::MAX_TAPS];
	tvfc_pkg::sample_t ir_ring_mem [tvfc_pkg::MAX_TAPS];

	tvfc_pkg::state_t  state_q;
	tvfc_pkg::taps_t   tap_count_q;
	tvfc_pkg::ptr_t    ptr_q;
	tvfc_pkg::ptr_t    clr_addr_q;
	tvfc_pkg::ptr_t    idx_q;
	tvfc_pkg::ptr_t    ridx_q;
	tvfc_pkg::taps_t   cnt_q;
	tvfc_pkg::acc_t    acc_q;
	logic              iss_s1;
	logic              iss_s2;
	tvfc_pkg::sample_t x_s1;
	tvfc_pkg::sample_t h_s1;
	tvfc_pkg::prod_t   prod_s2;
	logic              out_valid_q;
	tvfc_pkg::sample_t out_q;

	tvfc_pkg::taps_t   taps;
	tvfc_pkg::taps_t   ptr_inc;
	tvfc_pkg::ptr_t    ptr_next;
	tvfc_pkg::taps_t   idx_inc;
	tvfc_pkg::ptr_t    idx_next;
	logic              in_xfer;
	logic              out_xfer;
	logic              out_free;
	logic              clearing;
	logic              x_we;
	logic              h_we;
	tvfc_pkg::ptr_t    wr_addr;
	tvfc_pkg::sample_t x_wdata;
	tvfc_pkg::sample_t h_wdata;
	tvfc_pkg::acc_t    rnd_sum;
	logic signed [tvfc_pkg::QUOT_W-1:0] rnd_quot;
	tvfc_pkg::sample_t rnd_sat;

	always_comb begin
		if (tap_count_q == '0) begin
			taps = tvfc_pkg::TAP_W'(1);
		end else if (tap_count_q > tvfc_pkg::TAP_W'(tvfc_pkg::MAX_TAPS)) begin
			taps = tvfc_pkg::TAP_W'(tvfc_pkg::MAX_TAPS);
		end else begin
			taps = tap_count_q;
		end
	end

	assign in_stall = (state_q != tvfc_pkg::ST_IDLE);
	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign clearing = (state_q == tvfc_pkg::ST_CLEAR);

	assign ptr_inc  = {1'b0, ptr_q} + tvfc_pkg::TAP_W'(1);
	assign ptr_next = (ptr_inc >= taps) ? '0 : ptr_inc[tvfc_pkg::PTR_W-1:0];
	assign idx_inc  = {1'b0, idx_q} + tvfc_pkg::TAP_W'(1);
	assign idx_next = (idx_inc >= taps) ? '0 : idx_inc[tvfc_pkg::PTR_W-1:0];

	// ring write port: zero sweep after reset, else the accepted sample
	assign x_we    = clearing || (in_xfer && write_input);
	assign h_we    = clearing || (in_xfer && write_response);
	assign wr_addr = clearing ? clr_addr_q : ptr_q;
	assign x_wdata = clearing ? '0 : in_sample;
	assign h_wdata = clearing ? '0 : ir_sample;

	always_ff @(posedge clk) begin
		if (x_we) begin
			in_ring_mem[wr_addr] <= x_wdata;
		end
		if (h_we) begin
			ir_ring_mem[wr_addr] <= h_wdata;
		end
		x_s1 <= in_ring_mem[idx_q];
		h_s1 <= ir_ring_mem[ridx_q];
	end

	// round half up from Q12.30 to Q1.15, then saturate
	always_comb begin
		rnd_sum  = acc_q + tvfc_pkg::ACC_W'(1 << (tvfc_pkg::FRAC_W - 1));
		rnd_quot = rnd_sum[tvfc_pkg::ACC_W-1:tvfc_pkg::FRAC_W];
		if (rnd_quot > tvfc_pkg::QUOT_W'(32767)) begin
			rnd_sat = 16'sh7FFF;
		end else if (rnd_quot < -tvfc_pkg::QUOT_W'(32768)) begin
			rnd_sat = 16'sh8000;
		end else begin
			rnd_sat = rnd_quot[tvfc_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (iss_s1) begin
			prod_s2 <= x_s1 * h_s1;
		end
		if (in_xfer) begin
			acc_q <= '0;
		end else if (iss_s2) begin
			acc_q <= acc_q + {{(tvfc_pkg::ACC_W-tvfc_pkg::PROD_W){prod_s2[tvfc_pkg::PROD_W-1]}},
				prod_s2};
		end
		if (state_q == tvfc_pkg::ST_ROUND && out_free) begin
			out_q <= rnd_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tvfc_pkg::ST_CLEAR;
			tap_count_q <= tvfc_pkg::TAP_W'(tvfc_pkg::MAX_TAPS);
			ptr_q       <= '0;
			clr_addr_q  <= '0;
			idx_q       <= '0;
			ridx_q      <= '0;
			cnt_q       <= '0;
			iss_s1      <= 1'b0;
			iss_s2      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				tap_count_q <= cfg_wr_data;
			end
			iss_s1 <= (state_q == tvfc_pkg::ST_MAC);
			iss_s2 <= iss_s1;
			if (out_xfer && state_q != tvfc_pkg::ST_ROUND) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				tvfc_pkg::ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + tvfc_pkg::PTR_W'(1);
					if (clr_addr_q == '1) begin
						state_q <= tvfc_pkg::ST_IDLE;
					end
				end
				tvfc_pkg::ST_IDLE: begin
					if (in_xfer) begin
						ptr_q   <= ptr_next;
						idx_q   <= ptr_next;
						ridx_q  <= tvfc_pkg::PTR_W'(taps - tvfc_pkg::TAP_W'(1));
						cnt_q   <= taps;
						state_q <= tvfc_pkg::ST_MAC;
					end
				end
				tvfc_pkg::ST_MAC: begin
					idx_q  <= idx_next;
					ridx_q <= ridx_q - tvfc_pkg::PTR_W'(1);
					cnt_q  <= cnt_q - tvfc_pkg::TAP_W'(1);
					if (cnt_q == tvfc_pkg::TAP_W'(1)) begin
						state_q <= tvfc_pkg::ST_DRAIN;
					end
				end
				tvfc_pkg::ST_DRAIN: begin
					if (!iss_s1 && !iss_s2) begin
						state_q <= tvfc_pkg::ST_ROUND;
					end
				end
				tvfc_pkg::ST_ROUND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= tvfc_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= tvfc_pkg::ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_q;

endmodule

// ----- sim/tb_time_varying_fir_convolver.sv -----
// ----------------------------------------------------------------------------
// tb_time_varying_fir_convolver
// Self-checking bench for the direct-form time-varying FIR convolver. Input
// transfers feed a scoreboard that keeps its own copy of both rings, the
// shared pointer and the tap count, and predicts every output sample. Runs a
// directed set (extremes, saturation, rounding, degenerate tap counts, a
// pointer left beyond a lowered tap count) and then randomised phases over
// many tap counts with varying idle and stall pressure on both channels.
// ----------------------------------------------------------------------------
module tb_time_varying_fir_convolver;
	import tvfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = MAX_TAPS + 64;

	class convolution_scoreboard;
		sample_t     sample_ring[MAX_TAPS];
		sample_t     response_ring[MAX_TAPS];
		int unsigned wr_ptr;
		taps_t       tap_reg;
		sample_t     expected_q[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			foreach (sample_ring[i]) begin
				sample_ring[i]   = '0;
				response_ring[i] = '0;
			end
			wr_ptr  = 0;
			tap_reg = taps_t'(MAX_TAPS);
			errors  = 0;
			checked = 0;
		endfunction

		function void set_taps(taps_t v);
			tap_reg = v;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		function sample_t convolve(sample_t s, sample_t r, logic wi, logic wr);
			int unsigned n;
			int unsigned p;
			int unsigned idx;
			longint      acc;
			longint      q;
			if (tap_reg == 0)
				n = 1;
			else if (tap_reg > MAX_TAPS)
				n = MAX_TAPS;
			else
				n = tap_reg;
			p = wr_ptr % MAX_TAPS;
			if (wi)
				sample_ring[p] = s;
			if (wr)
				response_ring[p] = r;
			p++;
			if (p >= n)
				p = 0;
			wr_ptr = p;
			acc = 0;
			idx = p;
			for (int k = 0; k < n; k++) begin
				acc += longint'(sample_ring[idx]) * longint'(response_ring[n-1-k]);
				idx++;
				if (idx >= n)
					idx = 0;
			end
			// round half up, then saturate to Q1.15
			q = (acc + 64'sd16384) >>> 15;
			if (q > 32767)
				q = 32767;
			if (q < -32768)
				q = -32768;
			return sample_t'(q);
		endfunction

		function void note_transfer(sample_t s, sample_t r, logic wi, logic wr);
			expected_q.push_back(convolve(s, r, wi, wr));
		endfunction

		function void check_sample(sample_t got);
			sample_t exp_val;
			checked++;
			if (expected_q.size() == 0) begin
				$error("out_sample: no transfer outstanding, got %0d", got);
				errors++;
			end else begin
				exp_val = expected_q.pop_front();
				if (got !== exp_val) begin
					$error("out_sample: expected %0d, got %0d", exp_val, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic    clk            = 1'b0;
	logic    arst_n         = 1'b0;
	logic    in_valid       = 1'b0;
	logic    in_stall;
	sample_t in_sample      = '0;
	sample_t ir_sample      = '0;
	logic    write_input    = 1'b0;
	logic    write_response = 1'b0;
	logic    out_valid;
	logic    out_stall      = 1'b0;
	sample_t out_sample;
	logic    cfg_wr_en      = 1'b0;
	taps_t   cfg_wr_data    = '0;

	convolution_scoreboard sb = new();

	int          sender_idle_pct = 0;
	int          recv_stall_pct  = 0;
	int          idle_cycles     = 0;
	int unsigned sent           = 0;
	int unsigned settings_done  = 0;

	time_varying_fir_convolver dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_sample      (in_sample),
		.ir_sample      (ir_sample),
		.write_input    (write_input),
		.write_response (write_response),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_sample     (out_sample),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// output side: check results, random stall, watchdog
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_sample(out_sample);
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d outstanding",
				idle_cycles, sb.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// leaves in_valid high after the transfer; caller lowers it at phase end
	task automatic send_item(sample_t s, sample_t r, logic wi, logic wr);
		while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		in_sample      <= s;
		ir_sample      <= r;
		write_input    <= wi;
		write_response <= wr;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_transfer(s, r, wi, wr);
		sent++;
	endtask

	task automatic end_phase();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_taps(taps_t v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_taps(v);
		settings_done++;
	endtask

	function automatic sample_t rand_sample();
		case ($urandom_range(15))
			0:       return sample_t'(16'sh7fff);
			1:       return sample_t'(16'sh8000);
			2:       return sample_t'(-16'sd1);
			default: return sample_t'($urandom);
		endcase
	endfunction

	task automatic run_random(int unsigned n, int unsigned load_len);
		for (int unsigned k = 0; k < n; k++)
			send_item(rand_sample(), rand_sample(), $urandom_range(9) != 0,
				(k < load_len) ? 1'b1 : ($urandom_range(9) == 0));
		end_phase();
	endtask

	initial begin
		int unsigned n_items;
		int unsigned taps_val;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset tap count, full length rings
		send_item(16'sh7fff, 16'sh7fff, 1'b1, 1'b1);
		send_item(16'sh8000, 16'sh8000, 1'b1, 1'b1);
		send_item(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
		send_item(16'sh1234, -16'sd1, 1'b0, 1'b0);
		send_item(-16'sd1, 16'sd5, 1'b0, 1'b1);
		end_phase();

		// pointer now beyond the lowered count; drive into both saturation rails
		write_taps(taps_t'(4));
		repeat (4) send_item(16'sh8000, 16'sh8000, 1'b1, 1'b1);
		repeat (4) send_item(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
		end_phase();

		// zero taps acts as one; half-LSB rounding
		write_taps('0);
		send_item(16'sd100, 16'sd200, 1'b1, 1'b1);
		send_item(16'sd1, 16'sd16384, 1'b1, 1'b1);
		send_item(-16'sd1, 16'sd16384, 1'b1, 1'b1);
		send_item(-16'sd1, 16'sd16385, 1'b1, 1'b1);
		end_phase();

		// oversize count clamps to the full ring
		write_taps('1);
		send_item(16'sh4000, 16'sh4000, 1'b1, 1'b1);
		send_item(16'sh0001, 16'shfffe, 1'b1, 1'b1);
		end_phase();

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 77; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 77; end
				default: begin sender_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			n_items = 40;
			case (ph)
				5:  begin taps_val = MAX_TAPS; n_items = 6; end
				10: begin taps_val = $urandom_range(MAX_TAPS + 1, 2047); n_items = 4; end
				7:  taps_val = $urandom_range(200, 300);
				13: taps_val = 0;
				default: taps_val = $urandom_range(1, 48);
			endcase
			write_taps(taps_t'(taps_val));
			run_random(n_items, (taps_val == 0) ? 1 : taps_val);
		end

		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d input transfers sent, %0d output samples checked", sent, sb.checked);
		$display("tap count written %0d times, from zero up to the register maximum",
			settings_done);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
